// ----- sv/assert_macros.svh -----
// Assertion macros used by the checker module of the message queue.
// Depends on nothing; each macro takes a label, a clock, an active-low reset and two expressions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed one cycle later");

`endif

// ----- sv/tmrq_pkg.sv -----
// Types and codes of the typed message ring queue.
// Used by the queue top level and its checker; depends on nothing.
package tmrq_pkg;

  typedef enum logic [1:0] {
    KIND_SEND  = 2'd0,
    KIND_RECV  = 2'd1,
    KIND_PURGE = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_NOMATCH = 2'd2,
    STAT_NULL    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } state_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  msg_type;
    logic [31:0] msg_handle;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] handle_out;
    logic [5:0]  slot_index;
    logic [6:0]  removed_count;
  } out_item_t;

  // One stored entry: the type tag beside its handle.
  typedef struct packed {
    logic [7:0]  msg_type;
    logic [31:0] msg_handle;
  } mem_entry_t;

  localparam int ENTRY_W = $bits(mem_entry_t);

endpackage

// ----- sv/tmrq_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// Depends on nothing.
module tmrq_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/typed_message_ring_queue_top.sv -----
// Top level of the typed message ring queue: sequencer, pointers and result register.
// Depends on tmrq_pkg and tmrq_ram.
//
// Usage. Commands arrive as beats on the in_ channel (valid/stall) and each one gives
// exactly one result beat on the out_ channel. A send appends a handle and its type tag
// at the tail and reports the slot; a receive walks from the head, moving entries that
// do not match behind the tail until the first match is removed; a purge walks every
// entry once and drops those of the given type; a clear empties the queue at once.
// Throughput: one command at a time. A send, a clear, or a receive or purge on an empty
// queue goes from acceptance straight to the done state, which moves its result into the
// output register. A receive or purge on a non-empty queue first walks from the head: a
// receive stops at its first match, while a receive without a match or a purge reads
// every stored entry. The walk is paced by the single read port of the entry
// memory: one entry is read, and if kept written back at the tail, each cycle.
// The next command is accepted once the result has been moved into the output
// register, even if the receiver is still stalling that result beat.
// Reset empties the queue (head, tail and count to zero); the entry memory is not
// cleared, as only slots that hold stored entries are ever read.
// While out_stall is high the result beat is held unchanged in the output register.
module typed_message_ring_queue_top #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  tmrq_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output tmrq_pkg::out_item_t  out_data
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);
  localparam logic [AW-1:0] LAST_SLOT  = AW'(QUEUE_DEPTH - 1);

  // Advance a ring pointer, wrapping at the last slot.
  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == LAST_SLOT) ? '0 : p + AW'(1);
  endfunction

  // Control state.
  tmrq_pkg::state_t state_r, state_nxt;
  logic [AW-1:0]    head_r, head_nxt;
  logic [AW-1:0]    tail_r, tail_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             rd_v_r, rd_v_nxt;

  // Walk bookkeeping and latched command.
  tmrq_pkg::kind_t  kind_r, kind_nxt;
  logic [7:0]       type_r, type_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [AW-1:0]    proc_ptr_r, proc_ptr_nxt;
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [CW-1:0]    rd_cnt_r, rd_cnt_nxt;
  logic [CW-1:0]    proc_cnt_r, proc_cnt_nxt;
  logic [CW-1:0]    keep_cnt_r, keep_cnt_nxt;
  tmrq_pkg::out_item_t res_r, res_nxt;
  tmrq_pkg::out_item_t out_r, out_nxt;

  // Entry memory port signals.
  logic                      mem_we, mem_re;
  logic [AW-1:0]             mem_waddr, mem_raddr;
  tmrq_pkg::mem_entry_t      mem_wdata, rd_entry;
  logic [tmrq_pkg::ENTRY_W-1:0] mem_rdata;

  logic match, match_recv, issue, finish;

  tmrq_ram #(
    .WIDTH (tmrq_pkg::ENTRY_W),
    .DEPTH (QUEUE_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign rd_entry   = tmrq_pkg::mem_entry_t'(mem_rdata);
  assign match      = rd_v_r && (rd_entry.msg_type == type_r);
  assign match_recv = match && (kind_r == tmrq_pkg::KIND_RECV);

  assign in_stall  = (state_r != tmrq_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    kind_nxt      = kind_r;
    type_nxt      = type_r;
    rd_ptr_nxt    = rd_ptr_r;
    proc_ptr_nxt  = proc_ptr_r;
    wr_ptr_nxt    = wr_ptr_r;
    rd_cnt_nxt    = rd_cnt_r;
    proc_cnt_nxt  = proc_cnt_r;
    keep_cnt_nxt  = keep_cnt_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    rd_v_nxt      = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = wr_ptr_r;
    mem_wdata     = rd_entry;
    mem_re        = 1'b0;
    mem_raddr     = rd_ptr_r;
    issue         = 1'b0;
    finish        = 1'b0;

    case (state_r)
      tmrq_pkg::ST_IDLE: begin
        if (in_valid) begin
          kind_nxt     = in_data.kind;
          type_nxt     = in_data.msg_type;
          res_nxt      = '0;
          rd_ptr_nxt   = head_r;
          proc_ptr_nxt = head_r;
          wr_ptr_nxt   = tail_r;
          rd_cnt_nxt   = '0;
          proc_cnt_nxt = '0;
          keep_cnt_nxt = '0;
          state_nxt    = tmrq_pkg::ST_DONE;
          case (in_data.kind)
            tmrq_pkg::KIND_SEND: begin
              if (in_data.msg_handle == 32'd0) begin
                res_nxt.status = tmrq_pkg::STAT_NULL;
              end else if (count_r == FULL_COUNT) begin
                res_nxt.status = tmrq_pkg::STAT_FULL;
              end else begin
                mem_we             = 1'b1;
                mem_waddr          = tail_r;
                mem_wdata.msg_type   = in_data.msg_type;
                mem_wdata.msg_handle = in_data.msg_handle;
                res_nxt.slot_index = 6'(tail_r);
                tail_nxt           = ptr_inc(tail_r);
                count_nxt          = count_r + CW'(1);
              end
            end
            tmrq_pkg::KIND_RECV: begin
              if (count_r == '0) begin
                res_nxt.status = tmrq_pkg::STAT_NOMATCH;
              end else begin
                state_nxt = tmrq_pkg::ST_WALK;
              end
            end
            tmrq_pkg::KIND_PURGE: begin
              if (count_r != '0) begin
                state_nxt = tmrq_pkg::ST_WALK;
              end
            end
            tmrq_pkg::KIND_CLEAR: begin
              res_nxt.removed_count = 7'(count_r);
              head_nxt  = '0;
              tail_nxt  = '0;
              count_nxt = '0;
            end
            default: begin
              res_nxt.status = tmrq_pkg::STAT_OK;
            end
          endcase
        end
      end

      tmrq_pkg::ST_WALK: begin
        // Read side: one entry from the head each cycle until all are read or a receive's match shows.
        issue = (rd_cnt_r != count_r) && !match_recv;
        if (issue) begin
          mem_re     = 1'b1;
          mem_raddr  = rd_ptr_r;
          rd_ptr_nxt = ptr_inc(rd_ptr_r);
          rd_cnt_nxt = rd_cnt_r + CW'(1);
          rd_v_nxt   = 1'b1;
        end
        // Process side: the entry read last cycle leaves the head; a non-match
        // goes back at the tail. A written slot is either free or holds an entry already read.
        if (rd_v_r) begin
          proc_ptr_nxt = ptr_inc(proc_ptr_r);
          proc_cnt_nxt = proc_cnt_r + CW'(1);
          if (!match) begin
            mem_we       = 1'b1;
            mem_waddr    = wr_ptr_r;
            mem_wdata    = rd_entry;
            wr_ptr_nxt   = ptr_inc(wr_ptr_r);
            keep_cnt_nxt = keep_cnt_r + CW'(1);
          end
        end
        finish = match_recv || ((rd_cnt_r == count_r) && !rd_v_r);
        if (finish) begin
          head_nxt  = proc_ptr_nxt;
          tail_nxt  = wr_ptr_nxt;
          count_nxt = count_r - (proc_cnt_nxt - keep_cnt_nxt);
          if (kind_r == tmrq_pkg::KIND_RECV) begin
            if (match_recv) begin
              res_nxt.status     = tmrq_pkg::STAT_OK;
              res_nxt.handle_out = rd_entry.msg_handle;
            end else begin
              res_nxt.status = tmrq_pkg::STAT_NOMATCH;
            end
          end else begin
            res_nxt.removed_count = 7'(proc_cnt_nxt - keep_cnt_nxt);
          end
          state_nxt = tmrq_pkg::ST_DONE;
        end
      end

      tmrq_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = tmrq_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = tmrq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tmrq_pkg::ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      rd_v_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      rd_v_r      <= rd_v_nxt;
    end
  end

  // Payload and walk bookkeeping; always set up before use, so no reset.
  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    type_r     <= type_nxt;
    rd_ptr_r   <= rd_ptr_nxt;
    proc_ptr_r <= proc_ptr_nxt;
    wr_ptr_r   <= wr_ptr_nxt;
    rd_cnt_r   <= rd_cnt_nxt;
    proc_cnt_r <= proc_cnt_nxt;
    keep_cnt_r <= keep_cnt_nxt;
    res_r      <= res_nxt;
    out_r      <= out_nxt;
  end

endmodule

// ----- sv/tmrq_checker.sv -----
// Port-level checker of the typed message ring queue, bound to its top level.
// Depends on tmrq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tmrq_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input tmrq_pkg::out_item_t out_data
);

  logic res_failed;
  logic res_blank;
  logic res_single;

  assign res_failed = out_valid && (out_data.status != tmrq_pkg::STAT_OK);
  assign res_blank  = (out_data.handle_out == 32'd0) && (out_data.slot_index == 6'd0)
                      && (out_data.removed_count == 7'd0);
  assign res_single = (out_data.handle_out == 32'd0) || (out_data.removed_count == 7'd0);

  // A stalled result beat stays offered and unchanged.
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))

  // Commands are handled one at a time: an accepted beat blocks the next cycle.
  `ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && !in_stall, in_stall)

  // Failed or ignored commands carry no handle, slot or count.
  `ASSERT_SAME(a_fail_clean, clk, rst_n, res_failed, res_blank)

  // A result never both returns a handle and reports removed entries.
  `ASSERT_SAME(a_recv_or_remove, clk, rst_n, out_valid, res_single)

endmodule

bind typed_message_ring_queue_top tmrq_checker u_tmrq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
